>>> hw/rtl/mfb_pkg.sv
`default_nettype none
package mfb_pkg;

  localparam int PHYS_WIDTH  = 512;
  localparam int PHYS_HEIGHT = 256;
  localparam int PIC_BYTES   = 1024;

  // frame memory packs WORD_W horizontal pixels per word
  localparam int WORD_W      = 16;
  localparam int WORD_BITS   = $clog2(WORD_W);
  localparam int WPR         = PHYS_WIDTH / WORD_W;
  localparam int FRAME_WORDS = WPR * PHYS_HEIGHT;
  localparam int FA_W        = $clog2(FRAME_WORDS);
  localparam int PX_W        = $clog2(PHYS_WIDTH);
  localparam int PY_W        = $clog2(PHYS_HEIGHT);

  localparam int PIC_AW      = $clog2(PIC_BYTES);
  localparam int CNT_W       = PIC_AW + 1;
  localparam int NEED_W      = 19;

  // signed physical coordinate, covers offsets plus scaled picture span
  localparam int CW          = 14;
  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_ONE   = coord_t'(1);

  typedef enum logic [2:0] {
    MODE_PUT     = 3'd0,
    MODE_CLEAR   = 3'd1,
    MODE_INVERT  = 3'd2,
    MODE_OUTLINE = 3'd3,
    MODE_BLIT    = 3'd4,
    MODE_BYTE    = 3'd5,
    MODE_READ    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_TAKEN  = 2'd0,
    ST_DONE   = 2'd1,
    ST_READ   = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ROP_COPY  = 3'd0,
    ROP_AND   = 3'd1,
    ROP_OR    = 3'd2,
    ROP_KEEP  = 3'd3,
    ROP_CLEAR = 3'd4
  } rop_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FLIP   = 2'd2
  } cfg_e;

  function automatic coord_t sx10(input logic [9:0] v);
    return {{(CW-10){v[9]}}, v};
  endfunction

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mono_framebuffer_blitter_core.sv
// channel   dir  signals                               beat taken when
// s_axis    in   tvalid tready tdata[55:0] tuser[2:0]  tvalid & tready
// m_axis    out  tvalid tready tdata[7:0]  tuser[1:0]  tvalid & tready
// cfg       in   cfg_valid_i cfg_ready_o index data    cfg_valid_i & cfg_ready_o
//
// Simple commands (stray byte, reject, buffered picture byte) go from S_IDLE
// straight to S_RESP. Drawing visits physical pixels one at a time: S_RD
// reads the frame, then S_WR does read-modify-write on the single write port
// inside the clip area; a picture pixel that falls outside passes S_RD only.
// After reset a clearing pass writes all FRAME_WORDS (8192) words, 1 per
// cycle, with s_axis_tready low; cfg writes are taken at any time.
// The result sits in an output register, so the next beat may enter.
`default_nettype none
module mono_framebuffer_blitter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // x_first[9:0] y_first[19:10] x_last[29:20] y_last[39:30] pixel_value[40]
  // raster_op[43:41] scale[46:44] has_picture[47] picture_byte[55:48]
  input  wire logic [55:0] s_axis_tdata,
  // mode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_pixel[0], zero fill above
  output logic [7:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SETUP, S_BSETUP, S_RD, S_WR, S_RESP
  } state_e;

  typedef enum logic [2:0] {
    PO_COPY, PO_AND, PO_OR, PO_KEEP, PO_CLEAR, PO_INV, PO_READ
  } pix_op_e;

  localparam int CNT_W  = mfb_pkg::CNT_W;
  localparam int NEED_W = mfb_pkg::NEED_W;
  localparam int FA_W   = mfb_pkg::FA_W;
  localparam int PIC_AW = mfb_pkg::PIC_AW;
  localparam int WW     = mfb_pkg::WORD_W;

  state_e  state_q;
  pix_op_e pop_q;

  logic [FA_W-1:0] clr_q;
  logic [8:0]      sw_q;
  logic [7:0]      sh_q;
  logic [1:0]      flip_q;
  logic            pend_q, use_pic_q, src_q;
  logic [CNT_W-1:0] pic_cnt_q;
  logic            out_valid_q, out_rd_q;
  logic [1:0]      out_status_q;
  logic [1:0]      phase_q;
  logic [1:0]      rsp_status_q;
  logic            rsp_rd_q;

  logic [2:0]      c_mode_q;
  logic [9:0]      c_x1_q, c_y1_q, c_x2_q, c_y2_q;
  logic            c_pv_q;

  logic [9:0]      bl_x0_q, bl_y0_q;
  logic [10:0]     bl_w_q, bl_h_q;
  logic [2:0]      bl_op_q, bl_sc_q;
  logic [7:0]      bl_ppl_q;
  logic [NEED_W-1:0] bl_need_q;

  mfb_pkg::coord_t cur_x_q, cur_y_q, wx_lo_q, wx_hi_q, wy_hi_q;
  logic [9:0]      cx_q;
  logic [1:0]      subx_q, suby_q;
  logic [CNT_W-1:0] rowb_q;

  // input unpacking
  logic [2:0]  in_mode;
  logic [9:0]  in_x1, in_y1, in_x2, in_y2;
  logic        in_pv, in_hp;
  logic [2:0]  in_rop, in_scale, in_sc;
  logic [7:0]  in_byte;
  logic        in_acc;

  assign in_mode  = s_axis_tuser;
  assign in_x1    = s_axis_tdata[9:0];
  assign in_y1    = s_axis_tdata[19:10];
  assign in_x2    = s_axis_tdata[29:20];
  assign in_y2    = s_axis_tdata[39:30];
  assign in_pv    = s_axis_tdata[40];
  assign in_rop   = s_axis_tdata[43:41];
  assign in_scale = s_axis_tdata[46:44];
  assign in_hp    = s_axis_tdata[47];
  assign in_byte  = s_axis_tdata[55:48];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_rd_q};

  // blit command decode
  logic signed [11:0] in_w, in_h;
  logic               w_ok, h_ok;
  logic [7:0]         in_ppl;
  logic [NEED_W-1:0]  in_need;
  logic [CNT_W-1:0]   cnt_n;
  logic               rd_in_frame;

  always_comb begin
    in_w    = {{2{in_x2[9]}}, in_x2} - {{2{in_x1[9]}}, in_x1} + 12'sd1;
    in_h    = {{2{in_y2[9]}}, in_y2} - {{2{in_y1[9]}}, in_y1} + 12'sd1;
    w_ok    = !in_w[11] && (in_w != 12'sd0);
    h_ok    = !in_h[11] && (in_h != 12'sd0);
    in_ppl  = 8'((in_w[10:0] + 11'd7) >> 3);
    in_need = NEED_W'(in_ppl) * NEED_W'(in_h[10:0]);
    if (in_scale == 3'd0) begin
      in_sc = 3'd1;
    end else if (in_scale > 3'd4) begin
      in_sc = 3'd4;
    end else begin
      in_sc = in_scale;
    end
    cnt_n = pic_cnt_q + CNT_W'(1);
    rd_in_frame = (mfb_pkg::sx10(in_x1) >= 0) && (mfb_pkg::sx10(in_y1) >= 0) &&
                  (mfb_pkg::sx10(in_x1) < mfb_pkg::coord_t'(mfb_pkg::PHYS_WIDTH)) &&
                  (mfb_pkg::sx10(in_y1) < mfb_pkg::coord_t'(mfb_pkg::PHYS_HEIGHT));
  end

  // physical clip limits from the screen size
  mfb_pkg::coord_t xm, ym;
  assign xm = mfb_pkg::smin(mfb_pkg::coord_t'({sw_q, 1'b0}),
                            mfb_pkg::coord_t'(mfb_pkg::PHYS_WIDTH)) - mfb_pkg::C_ONE;
  assign ym = mfb_pkg::smin(mfb_pkg::coord_t'({sh_q, 1'b0}),
                            mfb_pkg::coord_t'(mfb_pkg::PHYS_HEIGHT)) - mfb_pkg::C_ONE;

  // rectangle setup: logical clip, then expand to 2x2 blocks
  mfb_pkg::coord_t ax1, ay1, ax2, ay2, lxs, lxe, lys, lye;
  logic            rect_empty;
  pix_op_e         rect_op;
  logic            rect_src;

  always_comb begin
    ax1 = mfb_pkg::sx10(c_x1_q);
    ay1 = mfb_pkg::sx10(c_y1_q);
    ax2 = mfb_pkg::sx10(c_x2_q);
    ay2 = mfb_pkg::sx10(c_y2_q);
    rect_op  = PO_COPY;
    rect_src = 1'b1;
    priority if (c_mode_q == mfb_pkg::MODE_PUT) begin
      ax2 = ax1;
      ay2 = ay1;
      rect_src = c_pv_q;
    end else if (c_mode_q == mfb_pkg::MODE_CLEAR) begin
      rect_src = 1'b0;
    end else if (c_mode_q == mfb_pkg::MODE_INVERT) begin
      rect_op = PO_INV;
    end else begin
      // outline: top row, bottom row, left column, right column
      unique case (phase_q)
        2'd0: ay2 = mfb_pkg::sx10(c_y1_q);
        2'd1: ay1 = mfb_pkg::sx10(c_y2_q);
        2'd2: ax2 = mfb_pkg::sx10(c_x1_q);
        default: ax1 = mfb_pkg::sx10(c_x2_q);
      endcase
    end
    lxs = mfb_pkg::smax(ax1, '0);
    lys = mfb_pkg::smax(ay1, '0);
    lxe = mfb_pkg::smin(mfb_pkg::smin(ax2, mfb_pkg::coord_t'(sw_q) - mfb_pkg::C_ONE),
                        mfb_pkg::coord_t'(mfb_pkg::PHYS_WIDTH / 2 - 1));
    lye = mfb_pkg::smin(mfb_pkg::smin(ay2, mfb_pkg::coord_t'(sh_q) - mfb_pkg::C_ONE),
                        mfb_pkg::coord_t'(mfb_pkg::PHYS_HEIGHT / 2 - 1));
    rect_empty = (lxs > lxe) || (lys > lye);
  end

  // blit setup
  mfb_pkg::coord_t ws, hs, ox, oy, bx_end, by_end, bx_lo, bx_hi, by_lo, by_hi;
  logic            blit_empty;
  pix_op_e         blit_op;
  logic [1:0]      scm1;
  logic [9:0]      cx_init;
  logic [1:0]      subx_init;

  always_comb begin
    ws     = mfb_pkg::coord_t'(bl_w_q) * mfb_pkg::coord_t'(bl_sc_q);
    hs     = mfb_pkg::coord_t'(bl_h_q) * mfb_pkg::coord_t'(bl_sc_q);
    ox     = mfb_pkg::sx10(bl_x0_q) + mfb_pkg::sx10(bl_x0_q);
    oy     = mfb_pkg::sx10(bl_y0_q) + mfb_pkg::sx10(bl_y0_q);
    bx_end = ox + ws - mfb_pkg::C_ONE;
    by_end = oy + hs - mfb_pkg::C_ONE;
    // with a picture the whole span is walked so the source counters
    // stay simple; off-screen pixels are skipped without a frame read or write
    if (use_pic_q) begin
      bx_lo = ox;
      bx_hi = bx_end;
      by_lo = oy;
      by_hi = by_end;
    end else begin
      bx_lo = mfb_pkg::smax(ox, '0);
      bx_hi = mfb_pkg::smin(bx_end, xm);
      by_lo = mfb_pkg::smax(oy, '0);
      by_hi = mfb_pkg::smin(by_end, ym);
    end
    blit_empty = (bx_lo > bx_hi) || (by_lo > by_hi);
    unique case (bl_op_q)
      mfb_pkg::ROP_COPY:  blit_op = PO_COPY;
      mfb_pkg::ROP_AND:   blit_op = PO_AND;
      mfb_pkg::ROP_OR:    blit_op = PO_OR;
      mfb_pkg::ROP_CLEAR: blit_op = PO_CLEAR;
      default:            blit_op = PO_KEEP;
    endcase
    scm1      = 2'(bl_sc_q - 3'd1);
    cx_init   = flip_q[0] ? 10'(bl_w_q - 11'd1) : 10'd0;
    subx_init = flip_q[0] ? scm1 : 2'd0;
  end

  // walk stepping
  mfb_pkg::coord_t nx_x, nx_y;
  logic [9:0]      nx_cx;
  logic [1:0]      nx_subx, nx_suby;
  logic [CNT_W-1:0] nx_rowb;
  logic            walk_done, inb;

  always_comb begin
    walk_done = (cur_x_q == wx_hi_q) && (cur_y_q == wy_hi_q);
    inb = (pop_q == PO_READ) ||
          ((cur_x_q >= 0) && (cur_y_q >= 0) && (cur_x_q <= xm) && (cur_y_q <= ym));
    nx_x    = cur_x_q + mfb_pkg::C_ONE;
    nx_y    = cur_y_q;
    nx_cx   = cx_q;
    nx_subx = subx_q;
    nx_rowb = rowb_q;
    nx_suby = suby_q;
    if (cur_x_q == wx_hi_q) begin
      nx_x    = wx_lo_q;
      nx_y    = cur_y_q + mfb_pkg::C_ONE;
      nx_cx   = cx_init;
      nx_subx = subx_init;
      if (flip_q[1]) begin
        if (suby_q == 2'd0) begin
          nx_suby = scm1;
          nx_rowb = rowb_q - CNT_W'(bl_ppl_q);
        end else begin
          nx_suby = suby_q - 2'd1;
        end
      end else begin
        if (suby_q == scm1) begin
          nx_suby = 2'd0;
          nx_rowb = rowb_q + CNT_W'(bl_ppl_q);
        end else begin
          nx_suby = suby_q + 2'd1;
        end
      end
    end else if (flip_q[0]) begin
      if (subx_q == 2'd0) begin
        nx_subx = scm1;
        nx_cx   = cx_q - 10'd1;
      end else begin
        nx_subx = subx_q - 2'd1;
      end
    end else begin
      if (subx_q == scm1) begin
        nx_subx = 2'd0;
        nx_cx   = cx_q + 10'd1;
      end else begin
        nx_subx = subx_q + 2'd1;
      end
    end
  end

  // end of a walk: next outline edge or the response
  state_e fin_state;
  logic [1:0] fin_status;
  always_comb begin
    if ((c_mode_q == mfb_pkg::MODE_OUTLINE) && (phase_q != 2'd3) && (pop_q != PO_READ)) begin
      fin_state = S_SETUP;
    end else begin
      fin_state = S_RESP;
    end
    fin_status = (pop_q == PO_READ) ? mfb_pkg::ST_READ : mfb_pkg::ST_DONE;
  end

  // memories
  logic [FA_W-1:0]   fa;
  logic [WW-1:0]     f_rdata, f_wdata, f_mod;
  logic              f_we, f_re, old_bit, new_bit, s_bit;
  logic [PIC_AW-1:0] pa;
  logic [7:0]        p_rdata;
  logic              p_we;

  assign fa = FA_W'(FA_W'(cur_y_q[mfb_pkg::PY_W-1:0]) * FA_W'(mfb_pkg::WPR)) +
              FA_W'(cur_x_q[mfb_pkg::PX_W-1:0] >> mfb_pkg::WORD_BITS);
  assign pa = PIC_AW'(rowb_q + CNT_W'(cx_q[9:3]));

  always_comb begin
    old_bit = f_rdata[cur_x_q[mfb_pkg::WORD_BITS-1:0]];
    s_bit   = use_pic_q ? p_rdata[~cx_q[2:0]] : src_q;
    unique case (pop_q)
      PO_COPY:  new_bit = s_bit;
      PO_AND:   new_bit = s_bit & old_bit;
      PO_OR:    new_bit = s_bit | old_bit;
      PO_CLEAR: new_bit = 1'b0;
      PO_INV:   new_bit = ~old_bit;
      default:  new_bit = old_bit;
    endcase
    f_mod = f_rdata;
    f_mod[cur_x_q[mfb_pkg::WORD_BITS-1:0]] = new_bit;
  end

  assign f_we    = (state_q == S_CLR) || ((state_q == S_WR) && (pop_q != PO_READ));
  assign f_wdata = (state_q == S_CLR) ? '0 : f_mod;
  assign f_re    = (state_q == S_RD) && inb;
  assign p_we    = in_acc && (in_mode == mfb_pkg::MODE_BYTE) && pend_q &&
                   (pic_cnt_q < CNT_W'(mfb_pkg::PIC_BYTES));

  mfb_ram #(.Width(WW), .Depth(mfb_pkg::FRAME_WORDS)) u_frame (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i ((state_q == S_CLR) ? clr_q : fa),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (fa),
    .rdata_o (f_rdata)
  );

  mfb_ram #(.Width(8), .Depth(mfb_pkg::PIC_BYTES)) u_pic (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pic_cnt_q[PIC_AW-1:0]),
    .wdata_i (in_byte),
    .re_i    (state_q == S_RD),
    .raddr_i (pa),
    .rdata_o (p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      sw_q         <= 9'd160;
      sh_q         <= 8'd96;
      flip_q       <= '0;
      pend_q       <= 1'b0;
      use_pic_q    <= 1'b0;
      src_q        <= 1'b0;
      pop_q        <= PO_KEEP;
      pic_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_rd_q     <= 1'b0;
      phase_q      <= '0;
      rsp_status_q <= '0;
      rsp_rd_q     <= 1'b0;
      c_mode_q     <= '0;
      c_x1_q       <= '0;
      c_y1_q       <= '0;
      c_x2_q       <= '0;
      c_y2_q       <= '0;
      c_pv_q       <= 1'b0;
      bl_x0_q      <= '0;
      bl_y0_q      <= '0;
      bl_w_q       <= '0;
      bl_h_q       <= '0;
      bl_op_q      <= '0;
      bl_sc_q      <= 3'd1;
      bl_ppl_q     <= '0;
      bl_need_q    <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      wx_lo_q      <= '0;
      wx_hi_q      <= '0;
      wy_hi_q      <= '0;
      cx_q         <= '0;
      subx_q       <= '0;
      suby_q       <= '0;
      rowb_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mfb_pkg::CFG_WIDTH:  sw_q   <= cfg_data_i;
          mfb_pkg::CFG_HEIGHT: sh_q   <= cfg_data_i[7:0];
          mfb_pkg::CFG_FLIP:   flip_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      // in S_RESP the output register is reloaded below instead
      if (out_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + FA_W'(1);
          if (clr_q == FA_W'(mfb_pkg::FRAME_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            c_mode_q <= in_mode;
            c_x1_q   <= in_x1;
            c_y1_q   <= in_y1;
            c_x2_q   <= in_x2;
            c_y2_q   <= in_y2;
            c_pv_q   <= in_pv;
            phase_q  <= '0;
            rsp_rd_q <= 1'b0;
            state_q  <= S_RESP;
            unique case (in_mode)
              mfb_pkg::MODE_PUT, mfb_pkg::MODE_CLEAR,
              mfb_pkg::MODE_INVERT, mfb_pkg::MODE_OUTLINE: begin
                use_pic_q <= 1'b0;
                state_q   <= S_SETUP;
              end
              mfb_pkg::MODE_BLIT: begin
                pend_q    <= 1'b0;
                pic_cnt_q <= '0;
                bl_x0_q   <= in_x1;
                bl_y0_q   <= in_y1;
                bl_w_q    <= in_w[10:0];
                bl_h_q    <= in_h[10:0];
                bl_op_q   <= in_rop;
                bl_sc_q   <= in_sc;
                bl_ppl_q  <= in_ppl;
                bl_need_q <= in_need;
                if (!w_ok || !h_ok) begin
                  rsp_status_q <= mfb_pkg::ST_DONE;
                end else if (!in_hp) begin
                  use_pic_q <= 1'b0;
                  state_q   <= S_BSETUP;
                end else if (in_need > NEED_W'(mfb_pkg::PIC_BYTES)) begin
                  rsp_status_q <= mfb_pkg::ST_REJECT;
                end else begin
                  pend_q       <= 1'b1;
                  rsp_status_q <= mfb_pkg::ST_TAKEN;
                end
              end
              mfb_pkg::MODE_BYTE: begin
                if (!p_we) begin
                  rsp_status_q <= mfb_pkg::ST_REJECT;
                end else if (NEED_W'(cnt_n) >= bl_need_q) begin
                  pend_q    <= 1'b0;
                  pic_cnt_q <= '0;
                  use_pic_q <= 1'b1;
                  state_q   <= S_BSETUP;
                end else begin
                  pic_cnt_q    <= cnt_n;
                  rsp_status_q <= mfb_pkg::ST_TAKEN;
                end
              end
              mfb_pkg::MODE_READ: begin
                if (rd_in_frame) begin
                  cur_x_q   <= mfb_pkg::sx10(in_x1);
                  cur_y_q   <= mfb_pkg::sx10(in_y1);
                  wx_lo_q   <= mfb_pkg::sx10(in_x1);
                  wx_hi_q   <= mfb_pkg::sx10(in_x1);
                  wy_hi_q   <= mfb_pkg::sx10(in_y1);
                  pop_q     <= PO_READ;
                  use_pic_q <= 1'b0;
                  state_q   <= S_RD;
                end else begin
                  rsp_status_q <= mfb_pkg::ST_REJECT;
                end
              end
              default: rsp_status_q <= mfb_pkg::ST_REJECT;
            endcase
          end
        end
        S_SETUP: begin
          pop_q   <= rect_op;
          src_q   <= rect_src;
          cur_x_q <= lxs + lxs;
          wx_lo_q <= lxs + lxs;
          wx_hi_q <= lxe + lxe + mfb_pkg::C_ONE;
          cur_y_q <= lys + lys;
          wy_hi_q <= lye + lye + mfb_pkg::C_ONE;
          if (rect_empty) begin
            phase_q      <= phase_q + 2'd1;
            rsp_status_q <= mfb_pkg::ST_DONE;
            state_q      <= (c_mode_q == mfb_pkg::MODE_OUTLINE && phase_q != 2'd3) ?
                            S_SETUP : S_RESP;
          end else begin
            state_q <= S_RD;
          end
        end
        S_BSETUP: begin
          pop_q   <= blit_op;
          src_q   <= 1'b0;
          cur_x_q <= bx_lo;
          wx_lo_q <= bx_lo;
          wx_hi_q <= bx_hi;
          cur_y_q <= by_lo;
          wy_hi_q <= by_hi;
          cx_q    <= cx_init;
          subx_q  <= subx_init;
          suby_q  <= flip_q[1] ? scm1 : 2'd0;
          rowb_q  <= flip_q[1] ? CNT_W'(bl_need_q - NEED_W'(bl_ppl_q)) : '0;
          if (blit_empty) begin
            rsp_status_q <= mfb_pkg::ST_DONE;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD, S_WR: begin
          if (state_q == S_WR && pop_q == PO_READ) begin
            rsp_rd_q <= old_bit;
          end
          if (state_q == S_RD && inb) begin
            state_q <= S_WR;
          end else if (walk_done) begin
            phase_q      <= phase_q + 2'd1;
            rsp_status_q <= fin_status;
            state_q      <= fin_state;
          end else begin
            cur_x_q <= nx_x;
            cur_y_q <= nx_y;
            cx_q    <= nx_cx;
            subx_q  <= nx_subx;
            suby_q  <= nx_suby;
            rowb_q  <= nx_rowb;
            state_q <= S_RD;
          end
        end
        S_RESP: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= rsp_status_q;
            out_rd_q     <= rsp_rd_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pend_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (bl_need_q != '0) && (bl_need_q <= NEED_W'(mfb_pkg::PIC_BYTES)))
    else $error("pending blit with bad byte count");

  a_cnt_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (NEED_W'(pic_cnt_q) < bl_need_q))
    else $error("picture byte count reached need while pending");

  a_wr_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && pop_q != PO_READ) |->
      (cur_x_q >= 0) && (cur_y_q >= 0) && (cur_x_q <= xm) && (cur_y_q <= ym))
    else $error("frame write outside clip area");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !m_axis_tready) |=> (state_q == S_RESP))
    else $error("response dropped while output full");

endmodule
`default_nettype wire

>>> hw/rtl/mfb_ram.sv
`default_nettype none
module mfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
